@@ hdl/lmsc_pkg.sv @@
// shared types, codes and constants of the led matrix scan controller
package lmsc_pkg;

    localparam int DEF_MAX_WIDTH = 256;
    localparam int DEF_MAX_ROWS  = 32;

    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 24;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 4;
    localparam int OP_ADDR_W  = 10;

    localparam logic [1:0] CMD_POINT = 2'd0;
    localparam logic [1:0] CMD_SCAN  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH_BLOCKS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROWS_32      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INVERT       = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DISPLAY_ON   = 2'd3;

    typedef enum logic [1:0] {
        OP_POINT,
        OP_SCAN,
        OP_CLEAR
    } op_kind_t;

    typedef struct packed {
        logic [3:0] width_blocks;
        logic       rows_32;
        logic       invert;
        logic       display_on;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        width_blocks: 4'd2,
        rows_32:      1'b0,
        invert:       1'b1,
        display_on:   1'b1
    };

    typedef struct packed {
        op_kind_t               kind;
        logic [OP_ADDR_W-1:0]   addr;
        logic [7:0]             bit_mask;
        logic                   pixel;
        logic [4:0]             row;
        logic [5:0]             per_row;
        logic                   invert;
    } op_t;

endpackage

@@ hdl/lmsc_front.sv @@
// command decode: coordinate wrap, address compute and scan row counter
module lmsc_front #(
    parameter int MAX_WIDTH = lmsc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_ROWS  = lmsc_pkg::DEF_MAX_ROWS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lmsc_pkg::S_DATA_W-1:0] s_tdata,
    input  lmsc_pkg::cfg_t                cfg,
    input  logic                          init_busy,
    input  logic                          q_full,
    output logic                          q_push,
    output lmsc_pkg::op_t                 q_op
);
    import lmsc_pkg::*;

    localparam int MAX_BLOCKS = MAX_WIDTH / 32;
    localparam bit ROWS32_OK  = (MAX_ROWS >= 32);

    logic [1:0]  cmd;
    logic [8:0]  x;
    logic [5:0]  y;
    logic        pixel;
    logic [3:0]  blocks;
    logic [8:0]  width;
    logic [5:0]  height;
    logic [5:0]  per_row;
    logic        rows_eff;
    logic [4:0]  row_mask;
    logic [8:0]  x_w;
    logic [5:0]  y_w;
    logic        in_panel;
    logic [10:0] point_addr;
    logic [10:0] scan_base;
    logic        accept;
    logic [4:0]  scan_row_reg;
    logic [4:0]  scan_row_next;

    assign cmd   = s_tdata[1:0];
    assign x     = s_tdata[10:2];
    assign y     = s_tdata[16:11];
    assign pixel = s_tdata[17];

    assign s_tready = !q_full && !init_busy;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        blocks = cfg.width_blocks;
        if (blocks == 4'd0) begin
            blocks = 4'd1;
        end
        if (blocks > 4'(MAX_BLOCKS)) begin
            blocks = 4'(MAX_BLOCKS);
        end
        width    = {blocks, 5'b00000};
        per_row  = {blocks, 2'b00};
        rows_eff = cfg.rows_32 && ROWS32_OK;
        height   = rows_eff ? 6'd32 : 6'd16;
        row_mask = rows_eff ? 5'd31 : 5'd15;

        x_w      = (x >= width) ? x - width : x;
        y_w      = (y >= height) ? y - height : y;
        in_panel = (x_w < width) && (y_w < height);

        point_addr = 11'(x_w[8:3]) + (11'(y_w[4:0]) * 11'(per_row));
        scan_base  = 11'(scan_row_reg) * 11'(per_row);

        q_op.kind     = OP_POINT;
        q_op.addr     = point_addr[OP_ADDR_W-1:0];
        q_op.bit_mask = 8'h80 >> x_w[2:0];
        q_op.pixel    = pixel;
        q_op.row      = scan_row_reg;
        q_op.per_row  = per_row;
        q_op.invert   = cfg.invert;
        q_push        = 1'b0;
        scan_row_next = scan_row_reg;

        unique case (cmd)
            CMD_POINT: begin
                q_push = accept && in_panel;
            end
            CMD_SCAN: begin
                q_op.kind = OP_SCAN;
                q_op.addr = scan_base[OP_ADDR_W-1:0];
                if (cfg.display_on) begin
                    q_push = accept;
                    if (accept) begin
                        scan_row_next = (scan_row_reg + 5'd1) & row_mask;
                    end
                end
            end
            CMD_CLEAR: begin
                q_op.kind = OP_CLEAR;
                q_push    = accept;
            end
            default: begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_row_reg <= '0;
        end else begin
            scan_row_reg <= scan_row_next;
        end
    end

endmodule

@@ hdl/lmsc_queue.sv @@
// two entry operation queue between decode and execution
module lmsc_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  lmsc_pkg::op_t push_op,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output lmsc_pkg::op_t pop_op
);
    import lmsc_pkg::*;

    op_t        entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full   = (count_reg == 2'd2);
    assign valid  = (count_reg != 2'd0);
    assign pop_op = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

@@ hdl/lmsc_back.sv @@
// frame store, clear sweep, point update and row scan output
module lmsc_back #(
    parameter int MAX_WIDTH = lmsc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_ROWS  = lmsc_pkg::DEF_MAX_ROWS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  lmsc_pkg::op_t                 q_op,
    output logic                          q_pop,
    output logic                          init_busy,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lmsc_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import lmsc_pkg::*;

    localparam int STORE_BYTES = (MAX_WIDTH * MAX_ROWS) / 8;
    localparam int ADDR_W      = $clog2(STORE_BYTES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_POINT_RD,
        S_POINT_WR,
        S_SCAN
    } state_t;

    logic [7:0] mem [STORE_BYTES];

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;
    logic                init_reg, init_next;
    logic [5:0]          b_reg, b_next;
    logic                d_vld_reg, d_vld_next;
    logic [4:0]          d_idx_reg, d_idx_next;
    logic                d_last_reg, d_last_next;
    logic [7:0]          rd_data_reg;
    logic                m_valid_reg, m_valid_next;
    logic [7:0]          m_byte_reg, m_byte_next;
    logic [4:0]          m_idx_reg, m_idx_next;
    logic                m_last_reg, m_last_next;
    logic [4:0]          m_row_reg, m_row_next;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [7:0]          mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [OP_ADDR_W-1:0] scan_addr;
    logic                d_move;

    assign scan_addr = op_reg.addr + OP_ADDR_W'(b_reg);
    assign d_move    = d_vld_reg && (!m_valid_reg || m_tready);

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        cnt_next     = cnt_reg;
        init_next    = init_reg;
        b_next       = b_reg;
        d_vld_next   = d_vld_reg;
        d_idx_next   = d_idx_reg;
        d_last_next  = d_last_reg;
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_idx_next   = m_idx_reg;
        m_last_next  = m_last_reg;
        m_row_next   = m_row_reg;
        mem_we       = 1'b0;
        mem_waddr    = cnt_reg;
        mem_wdata    = 8'h00;
        mem_re       = 1'b0;
        mem_raddr    = op_reg.addr[ADDR_W-1:0];
        q_pop        = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (d_move) begin
            m_valid_next = 1'b1;
            m_byte_next  = rd_data_reg ^ {8{op_reg.invert}};
            m_idx_next   = d_idx_reg;
            m_last_next  = d_last_reg;
            m_row_next   = op_reg.row;
            d_vld_next   = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ADDR_W'(STORE_BYTES - 1)) begin
                    cnt_next   = '0;
                    init_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (q_valid) begin
                    q_pop   = 1'b1;
                    op_next = q_op;
                    b_next  = '0;
                    unique case (q_op.kind)
                        OP_POINT: state_next = S_POINT_RD;
                        OP_SCAN:  state_next = S_SCAN;
                        OP_CLEAR: state_next = S_CLEAR;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_POINT_RD: begin
                mem_re     = 1'b1;
                state_next = S_POINT_WR;
            end
            S_POINT_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = op_reg.addr[ADDR_W-1:0];
                mem_wdata  = op_reg.pixel ? (rd_data_reg | op_reg.bit_mask)
                                          : (rd_data_reg & ~op_reg.bit_mask);
                state_next = S_IDLE;
            end
            S_SCAN: begin
                if (b_reg < op_reg.per_row) begin
                    if (!d_vld_reg || d_move) begin
                        mem_re      = 1'b1;
                        mem_raddr   = scan_addr[ADDR_W-1:0];
                        d_vld_next  = 1'b1;
                        d_idx_next  = b_reg[4:0];
                        d_last_next = ((b_reg + 6'd1) == op_reg.per_row);
                        b_next      = b_reg + 6'd1;
                    end
                end else if (!d_vld_reg || d_move) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            init_reg    <= 1'b1;
            d_vld_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            init_reg    <= init_next;
            d_vld_reg   <= d_vld_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg     <= op_next;
        b_reg      <= b_next;
        d_idx_reg  <= d_idx_next;
        d_last_reg <= d_last_next;
        m_byte_reg <= m_byte_next;
        m_idx_reg  <= m_idx_next;
        m_last_reg <= m_last_next;
        m_row_reg  <= m_row_next;
    end

    assign init_busy = init_reg;
    assign m_tvalid  = m_valid_reg;
    assign m_tlast   = m_last_reg;
    assign m_tdata   = {6'b000000, m_idx_reg, m_row_reg[3:0], m_row_reg[4], m_byte_reg};

endmodule

@@ hdl/led_matrix_scan_controller.sv @@
// top level: config registers, decode front, op queue, store and scan back end
// point write: pop, read, write per item; the store is updated in the write step
// scan: each byte passes a read register and then the output register; one byte per
// cycle while m_tready is high; rate is set by the single read port of the frame store,
// one access per cycle; reset: registers take their defaults, scan row goes to 0, the
// store of MAX_WIDTH*MAX_ROWS/8 bytes (1024 by default) is swept to zero, s_tready low
module led_matrix_scan_controller #(
    parameter int MAX_WIDTH = lmsc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_ROWS  = lmsc_pkg::DEF_MAX_ROWS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // cmd[1:0], x[10:2], y[16:11], pixel[17], zero fill above
    input  logic [lmsc_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_byte[7:0], lower_half[8], row_address[12:9], byte_index[17:13], zero fill above
    output logic [lmsc_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [lmsc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lmsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import lmsc_pkg::*;

    cfg_t cfg_reg;
    logic init_busy;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    op_t  push_op;
    op_t  pop_op;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_WIDTH_BLOCKS: cfg_reg.width_blocks <= cfg_wdata;
                REG_ROWS_32:      cfg_reg.rows_32      <= cfg_wdata[0];
                REG_INVERT:       cfg_reg.invert       <= cfg_wdata[0];
                REG_DISPLAY_ON:   cfg_reg.display_on   <= cfg_wdata[0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    lmsc_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg       (cfg_reg),
        .init_busy (init_busy),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_op      (push_op)
    );

    lmsc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .pop_op  (pop_op)
    );

    lmsc_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_op      (pop_op),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    a_no_accept_during_init: assert property (@(posedge aclk) disable iff (!aresetn)
        init_busy |-> !s_tready)
        else $error("input accepted during store init sweep");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("op queue overflow");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("op queue underflow");
`endif

endmodule

@@ tb/led_matrix_scan_controller_test.sv @@
// self-checking testbench for the led matrix scan controller: directed table, then random phases
`timescale 1ns / 1ps

module led_matrix_scan_controller_test;
    import lmsc_pkg::*;

    localparam int STORE_BYTES   = DEF_MAX_WIDTH * DEF_MAX_ROWS / 8;
    localparam int SETTLE_CYCLES = STORE_BYTES + 200;
    localparam int HOLD_CYCLES   = 500;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int MAX_SHOWN     = 40;
    localparam int DIR_ROWS      = 28;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       lower_half;
        logic [3:0] row_address;
        logic [4:0] byte_index;
        logic       last;
    } scan_byte_t;

    typedef struct packed {
        logic [S_DATA_W-1:0] tdata;
        logic                fixed;
        logic [7:0]          fix_byte;
        logic [4:0]          fix_row;
        logic [5:0]          fix_count;
    } stim_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        stim_t                 stim;
    } dir_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // predictor state
    logic [7:0]   frame_mirror [0:STORE_BYTES-1];
    logic [4:0]   row_m;
    cfg_t         cfg_m;
    scan_byte_t   row_bytes_q [$];
    stim_t        send_q [$];
    stim_t        cur_stim;
    dir_row_t     dir_tab [DIR_ROWS];

    int  gap_left   = 0;
    int  burst_left = 1;
    int  rx_mode    = 0;
    int  rx_cnt     = 0;
    int  hold_left  = 0;
    bit  hold_req   = 1'b0;
    bit  hold_done  = 1'b0;
    bit  dirty      = 1'b0;
    logic rdy;
    int  errors     = 0;
    int  shown      = 0;
    int  n_in       = 0;
    int  n_out      = 0;
    int  n_cfg      = 0;
    int  cycles     = 0;

    led_matrix_scan_controller i_dut (
        .aclk,
        .aresetn,
        .s_tvalid,
        .s_tready,
        .s_tdata,
        .m_tvalid,
        .m_tready,
        .m_tdata,
        .m_tlast,
        .cfg_we,
        .cfg_addr,
        .cfg_wdata
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned panel_cols();
        int unsigned blocks;
        blocks = cfg_m.width_blocks;
        if (blocks < 1) blocks = 1;
        if (blocks > DEF_MAX_WIDTH / 32) blocks = DEF_MAX_WIDTH / 32;
        return blocks * 32;
    endfunction

    function automatic int unsigned panel_rows();
        return (cfg_m.rows_32 && DEF_MAX_ROWS >= 32) ? 32 : 16;
    endfunction

    function automatic stim_t plain_item(logic [1:0] cmd, int unsigned x, int unsigned y,
                                         logic pixel);
        stim_t it;
        it = '0;
        it.tdata[1:0]   = cmd;
        it.tdata[10:2]  = x[8:0];
        it.tdata[16:11] = y[5:0];
        it.tdata[17]    = pixel;
        return it;
    endfunction

    function automatic dir_row_t item_row(logic [1:0] cmd, int unsigned x, int unsigned y,
                                          logic pixel);
        dir_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.stim = plain_item(cmd, x, y, pixel);
        return r;
    endfunction

    function automatic dir_row_t fixed_scan(logic [7:0] byte_v, logic [4:0] row_v,
                                            logic [5:0] count_v);
        dir_row_t r;
        r = '0;
        r.kind           = ROW_ITEM;
        r.stim           = plain_item(CMD_SCAN, 0, 0, 1'b0);
        r.stim.fixed     = 1'b1;
        r.stim.fix_byte  = byte_v;
        r.stim.fix_row   = row_v;
        r.stim.fix_count = count_v;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        dir_row_t r;
        r = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // works out the result bytes of one accepted transaction and updates the mirror
    task automatic apply_item(stim_t it);
        logic [1:0]  cmd;
        logic        pix;
        logic [7:0]  mask;
        logic [7:0]  raw;
        int unsigned x, y, w, h, addr, per_row, row, b;
        scan_byte_t  sb;
        cmd = it.tdata[1:0];
        x   = it.tdata[10:2];
        y   = it.tdata[16:11];
        pix = it.tdata[17];
        w   = panel_cols();
        h   = panel_rows();
        case (cmd)
            CMD_POINT: begin
                if (x >= w) x -= w;
                if (y >= h) y -= h;
                if (x < w && y < h) begin
                    addr = x / 8 + y * (w / 8);
                    if (addr < STORE_BYTES) begin
                        if (pix) frame_mirror[addr] = frame_mirror[addr] | (8'h80 >> (x % 8));
                        else frame_mirror[addr] = frame_mirror[addr] & ~(8'h80 >> (x % 8));
                    end
                end
            end
            CMD_SCAN: begin
                if (cfg_m.display_on) begin
                    per_row = w / 8;
                    row     = row_m;
                    mask    = cfg_m.invert ? 8'hff : 8'h00;
                    for (b = 0; b < per_row; b++) begin
                        addr           = row * per_row + b;
                        raw            = (addr < STORE_BYTES) ? frame_mirror[addr] : 8'h00;
                        sb.pixel_byte  = raw ^ mask;
                        sb.lower_half  = row_m[4];
                        sb.row_address = row_m[3:0];
                        sb.byte_index  = b[4:0];
                        sb.last        = (b + 1 == per_row);
                        if (!it.fixed) row_bytes_q.push_back(sb);
                    end
                    row_m = 5'((row + 1) & (h - 1));
                end
            end
            CMD_CLEAR: begin
                foreach (frame_mirror[i]) frame_mirror[i] = 8'h00;
            end
            default: ;
        endcase
        if (it.fixed) begin
            for (b = 0; b < it.fix_count; b++) begin
                sb.pixel_byte  = it.fix_byte;
                sb.lower_half  = it.fix_row[4];
                sb.row_address = it.fix_row[3:0];
                sb.byte_index  = b[4:0];
                sb.last        = (b + 1 == it.fix_count);
                row_bytes_q.push_back(sb);
            end
        end
    endtask

    task automatic report_field(string what, int unsigned want, int unsigned got);
        errors++;
        if (shown < MAX_SHOWN) begin
            $display("[%0t] %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        end else if (shown == MAX_SHOWN) begin
            $display("[%0t] further mismatches not shown", $time);
        end
        shown++;
    endtask

    task automatic check_result();
        scan_byte_t got, want;
        got.pixel_byte  = m_tdata[7:0];
        got.lower_half  = m_tdata[8];
        got.row_address = m_tdata[12:9];
        got.byte_index  = m_tdata[17:13];
        got.last        = m_tlast;
        n_out++;
        if (row_bytes_q.size() == 0) begin
            report_field("unexpected transaction, m_tdata", 0, m_tdata);
        end else begin
            want = row_bytes_q.pop_front();
            if (got.pixel_byte !== want.pixel_byte)
                report_field("pixel_byte", want.pixel_byte, got.pixel_byte);
            if (got.lower_half !== want.lower_half)
                report_field("lower_half", want.lower_half, got.lower_half);
            if (got.row_address !== want.row_address)
                report_field("row_address", want.row_address, got.row_address);
            if (got.byte_index !== want.byte_index)
                report_field("byte_index", want.byte_index, got.byte_index);
            if (got.last !== want.last)
                report_field("last", want.last, got.last);
        end
    endtask

    // input side: bursts of random length with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_item(cur_stim);
                n_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (send_q.size() > 0) begin
                    cur_stim = send_q.pop_front();
                    s_tdata  <= cur_stim.tdata;
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: stall pattern switches at random among four modes, plus one long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_result();
            if (rx_cnt == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_cnt  = $urandom_range(20, 80);
            end else begin
                rx_cnt--;
            end
            case (rx_mode)
                0:       rdy = 1'b1;
                1:       rdy = 1'($urandom_range(0, 1));
                2:       rdy = ($urandom_range(0, 4) != 0);
                default: rdy = ((rx_cnt % 3) != 0);
            endcase
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rdy       = 1'b0;
            end
            m_tready <= rdy;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("[%0t] timeout after %0d cycles", $time, cycles);
            $display("led_matrix_scan_controller_test: FAIL");
            $finish;
        end
    end

    task automatic push_item(stim_t it);
        while (send_q.size() >= 4) @(negedge aclk);
        send_q.push_back(it);
        dirty = 1'b1;
    endtask

    // everything accepted and answered, then room for a trailing clear sweep
    task automatic wait_idle();
        while (!(send_q.size() == 0 && !s_tvalid && row_bytes_q.size() == 0)) @(negedge aclk);
        if (dirty) begin
            repeat (SETTLE_CYCLES) @(negedge aclk);
            dirty = 1'b0;
        end
    endtask

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_WIDTH_BLOCKS: cfg_m.width_blocks = val;
            REG_ROWS_32:      cfg_m.rows_32      = val[0];
            REG_INVERT:       cfg_m.invert       = val[0];
            REG_DISPLAY_ON:   cfg_m.display_on   = val[0];
            default: ;
        endcase
        n_cfg++;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned w, h, x, y, r, target, counted;
        logic [1:0]  cmd;
        logic        pix;
        logic [2:0]  junk;
        logic [3:0]  width_val;

        foreach (frame_mirror[i]) frame_mirror[i] = 8'h00;
        row_m = '0;
        cfg_m = CFG_RESET;

        dir_tab = '{
            fixed_scan(8'hff, 5'd0, 6'd8),
            item_row(CMD_POINT, 0, 1, 1'b1),
            item_row(CMD_POINT, 63, 1, 1'b1),
            item_row(CMD_POINT, 65, 17, 1'b1),
            item_row(CMD_POINT, 100, 1, 1'b1),
            item_row(CMD_POINT, 511, 63, 1'b1),
            item_row(CMD_POINT, 0, 40, 1'b1),
            item_row(CMD_UNUSED, 511, 63, 1'b1),
            item_row(CMD_POINT, 0, 1, 1'b0),
            item_row(CMD_SCAN, 0, 0, 1'b0),
            cfg_row(REG_INVERT, 4'd0),
            cfg_row(REG_WIDTH_BLOCKS, 4'd0),
            item_row(CMD_POINT, 31, 2, 1'b1),
            item_row(CMD_SCAN, 0, 0, 1'b0),
            cfg_row(REG_DISPLAY_ON, 4'd0),
            fixed_scan(8'h00, 5'd3, 6'd0),
            cfg_row(REG_DISPLAY_ON, 4'd1),
            cfg_row(REG_WIDTH_BLOCKS, 4'd15),
            cfg_row(REG_ROWS_32, 4'd1),
            item_row(CMD_POINT, 255, 31, 1'b1),
            item_row(CMD_POINT, 511, 63, 1'b1),
            item_row(CMD_CLEAR, 0, 0, 1'b0),
            fixed_scan(8'h00, 5'd3, 6'd32),
            item_row(CMD_POINT, 0, 4, 1'b1),
            item_row(CMD_SCAN, 0, 0, 1'b0),
            cfg_row(REG_INVERT, 4'b1111),
            item_row(CMD_POINT, 128, 5, 1'b1),
            item_row(CMD_SCAN, 511, 63, 1'b1)
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                wait_idle();
                cfg_write(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            end else begin
                push_item(dir_tab[i].stim);
            end
        end

        for (int p = 0; p < 8; p++) begin
            wait_idle();
            case (p)
                0:       width_val = 4'd8;
                1:       width_val = 4'd1;
                2:       width_val = 4'd0;
                3:       width_val = 4'd15;
                default: width_val = 4'($urandom_range(0, 15));
            endcase
            cfg_write(REG_WIDTH_BLOCKS, width_val);
            junk = 3'($urandom_range(0, 7));
            cfg_write(REG_ROWS_32, {junk, p % 2 == 0});
            junk = 3'($urandom_range(0, 7));
            cfg_write(REG_INVERT, {junk, (p < 2) ? p[0] : 1'($urandom_range(0, 1))});
            junk = 3'($urandom_range(0, 7));
            cfg_write(REG_DISPLAY_ON, {junk, p != 5});
            w       = panel_cols();
            h       = panel_rows();
            target  = (p == 5) ? 12 : 34;
            counted = 0;
            while (counted < target) begin
                if (p == 3 && counted == 10) hold_req = 1'b1;
                r   = $urandom_range(0, 99);
                x   = $urandom_range(0, 511);
                y   = $urandom_range(0, 63);
                pix = 1'($urandom_range(0, 1));
                if (r < 50) begin
                    cmd = CMD_POINT;
                    x   = $urandom_range(0, w - 1);
                    if ($urandom_range(0, 9) < 6) y = (row_m + $urandom_range(0, 2)) % h;
                    else y = $urandom_range(0, h - 1);
                    pix = ($urandom_range(0, 9) < 7);
                end else if (r < 58) begin
                    cmd = CMD_POINT;
                    x   = $urandom_range(0, 2 * w - 1);
                    y   = $urandom_range(0, 2 * h - 1);
                end else if (r < 63) begin
                    cmd = CMD_POINT;
                end else if (r < 95) begin
                    cmd = CMD_SCAN;
                end else if (r < 97) begin
                    cmd = CMD_CLEAR;
                end else begin
                    cmd = CMD_UNUSED;
                end
                push_item(plain_item(cmd, x, y, pix));
                if (cmd != CMD_UNUSED) counted++;
            end
        end

        wait_idle();
        $display("run covered %0d input transactions, %0d output transactions, %0d register writes",
                 n_in, n_out, n_cfg);
        $display("with wrapped and outside points, clears, blanked scans and a long output hold");
        if (errors == 0 && row_bytes_q.size() == 0) begin
            $display("led_matrix_scan_controller_test: PASS");
        end else begin
            $display("led_matrix_scan_controller_test: FAIL");
        end
        $finish;
    end

endmodule
